// ----- design/bfm_pkg.sv -----
// Shared constants, codes and types for the brainfuck machine core.
`default_nettype none

package bfm_pkg;

    // Default sizes
    localparam int PROG_DEPTH_DEF = 4096;
    localparam int TAPE_HALF_DEF  = 8192;
    localparam int NEST_DEPTH_DEF = 256;
    localparam int CELL_BITS_DEF  = 8;

    // Instruction limit for one request, and the counter that tracks it
    localparam int STEP_BUDGET = 65536;
    localparam int STEP_W      = $clog2(STEP_BUDGET) + 1;

    // Fixed field widths
    localparam int POS_W  = 12;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 4;
    localparam int CMD_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ON_EOF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_ADDR   = 2'd2;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_END    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SUPPLY = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 4'd0;
    localparam logic [STAT_W-1:0] ST_FINISHED  = 4'd1;
    localparam logic [STAT_W-1:0] ST_OUTPUT    = 4'd2;
    localparam logic [STAT_W-1:0] ST_NEED_IN   = 4'd3;
    localparam logic [STAT_W-1:0] ST_BREAK     = 4'd4;
    localparam logic [STAT_W-1:0] ST_EOF_STOP  = 4'd5;
    localparam logic [STAT_W-1:0] ST_UNM_CLOSE = 4'd6;
    localparam logic [STAT_W-1:0] ST_UNM_OPEN  = 4'd7;
    localparam logic [STAT_W-1:0] ST_TAPE_OVF  = 4'd8;
    localparam logic [STAT_W-1:0] ST_PROG_FULL = 4'd9;
    localparam logic [STAT_W-1:0] ST_NEST_OVF  = 4'd10;

    // Stored opcodes
    localparam logic [2:0] OP_INC   = 3'd0;
    localparam logic [2:0] OP_DEC   = 3'd1;
    localparam logic [2:0] OP_RIGHT = 3'd2;
    localparam logic [2:0] OP_LEFT  = 3'd3;
    localparam logic [2:0] OP_OPEN  = 3'd4;
    localparam logic [2:0] OP_CLOSE = 3'd5;
    localparam logic [2:0] OP_OUT   = 3'd6;
    localparam logic [2:0] OP_IN    = 3'd7;

    // Program characters
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;

    // One result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  prog_pos;
    } res_t;

    // Character to opcode; top bit set when the character is a command
    function automatic logic [3:0] char_to_op(input logic [7:0] ch);
        logic [3:0] r;
        unique case (ch)
            CH_INC:   r = {1'b1, OP_INC};
            CH_DEC:   r = {1'b1, OP_DEC};
            CH_RIGHT: r = {1'b1, OP_RIGHT};
            CH_LEFT:  r = {1'b1, OP_LEFT};
            CH_OPEN:  r = {1'b1, OP_OPEN};
            CH_CLOSE: r = {1'b1, OP_CLOSE};
            CH_OUT:   r = {1'b1, OP_OUT};
            CH_IN:    r = {1'b1, OP_IN};
            default:  r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/brainfuck_machine_core.sv -----
// Brainfuck machine core: program loader, bracket pairing and tape executor.
//
// Requests arrive on s_* (valid/ready) and each gives exactly one result on m_*.
// Load requests store command characters and pair brackets through a stack
// memory. A run request first clears both tape halves, one cell per half per
// cycle, then executes. Each instruction is fetched from the program, partner
// and tape memories, then executed and written back; up to 65536 instructions
// run per request, until a pause: output byte, input wanted, breakpoint, end
// of input stop, fault or program end.
// Resume and supply requests continue from the pause without clearing.
// Results are held in an output register; a new request is taken while a
// result waits, and a finished request waits for the register to drain.
// After reset the tape is cleared in the same way before the first request
// is taken; configuration writes are taken at any time.
// cfg_wr_en writes register cfg_index: 0 stop_on_eof, 1 break_enable,
// 2 break_addr.
`default_nettype none

module brainfuck_machine_core
    import bfm_pkg::*;
#(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF,
    parameter int TAPE_HALF  = TAPE_HALF_DEF,
    parameter int NEST_DEPTH = NEST_DEPTH_DEF,
    parameter int CELL_BITS  = CELL_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Requests
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CMD_W-1:0]      s_cmd,
    input  wire logic [BYTE_W-1:0]     s_data_byte,
    input  wire logic                  s_in_eof,
    // Results
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [STAT_W-1:0]          m_status,
    output logic [BYTE_W-1:0]          m_out_byte,
    output logic [POS_W-1:0]           m_prog_pos
);

    localparam int PA = $clog2(PROG_DEPTH);
    localparam int TA = $clog2(TAPE_HALF);
    localparam int SA = $clog2(NEST_DEPTH);
    localparam int CB = CELL_BITS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LD_J1, S_LD_J2, S_START, S_FETCH, S_EXEC, S_EMIT
    } state_t;

    // Memories
    logic [2:0]    prog_mem [PROG_DEPTH];
    logic [PA-1:0] jmp_mem  [PROG_DEPTH];
    logic [PA-1:0] stk_mem  [NEST_DEPTH];
    logic [CB-1:0] tape_r   [TAPE_HALF];
    logic [CB-1:0] tape_l   [TAPE_HALF];

    logic [2:0]    prog_rd;
    logic [PA-1:0] jmp_rd, stk_rd;
    logic [CB-1:0] tape_r_rd, tape_l_rd;

    logic          prog_we, jmp_we, stk_we, tape_we_r, tape_we_l;
    logic [PA-1:0] prog_wa, jmp_wa, jmp_wd, stk_wd;
    logic [2:0]    prog_wd;
    logic [SA-1:0] stk_wa, stk_ra;
    logic [TA-1:0] tape_wa;
    logic [CB-1:0] tape_wd;

    // Control state
    state_t          state_reg, state_next;
    logic            stop_on_eof_reg, break_enable_reg;
    logic [POS_W-1:0] break_addr_reg;
    logic [SA:0]     sd_reg, sd_next;
    logic [PA:0]     lc_reg, lc_next;
    logic [PA:0]     pc_reg, pc_next;
    logic            side_reg, side_next;
    logic [TA-1:0]   idx_reg, idx_next;
    logic            awaiting_reg, awaiting_next;
    logic            paused_reg, paused_next;
    logic            skip_reg, skip_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TA-1:0]   clr_reg, clr_next;
    logic            clr_run_reg, clr_run_next;
    logic [PA-1:0]   partner_reg, partner_next;
    res_t            res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    res_t            m_res_reg, m_res_next;

    logic [3:0]      ld_op;
    logic [CB-1:0]   cur_cell;
    logic            to_left;

    function automatic logic [POS_W-1:0] pos12(input logic [PA:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[POS_W-1:0];
    endfunction

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_status   = m_res_reg.status;
    assign m_out_byte = m_res_reg.out_byte;
    assign m_prog_pos = m_res_reg.prog_pos;

    assign ld_op    = char_to_op(s_data_byte);
    assign cur_cell = side_reg ? tape_l_rd : tape_r_rd;
    assign to_left  = (prog_rd == OP_LEFT);
    assign stk_ra   = SA'(sd_reg - 1'b1);

    // Program and partner memories: read at the program counter every cycle
    always_ff @(posedge aclk) begin
        if (prog_we) prog_mem[prog_wa] <= prog_wd;
        prog_rd <= prog_mem[pc_reg[PA-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (jmp_we) jmp_mem[jmp_wa] <= jmp_wd;
        jmp_rd <= jmp_mem[pc_reg[PA-1:0]];
    end

    // Open bracket stack: read at the top entry every cycle
    always_ff @(posedge aclk) begin
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        stk_rd <= stk_mem[stk_ra];
    end

    // Tape halves: read at the head every cycle
    always_ff @(posedge aclk) begin
        if (tape_we_r) tape_r[tape_wa] <= tape_wd;
        tape_r_rd <= tape_r[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (tape_we_l) tape_l[tape_wa] <= tape_wd;
        tape_l_rd <= tape_l[idx_reg];
    end

    // Next state and memory control
    always_comb begin
        state_next    = state_reg;
        sd_next       = sd_reg;
        lc_next       = lc_reg;
        pc_next       = pc_reg;
        side_next     = side_reg;
        idx_next      = idx_reg;
        awaiting_next = awaiting_reg;
        paused_next   = paused_reg;
        skip_next     = skip_reg;
        step_next     = step_reg;
        clr_next      = clr_reg;
        clr_run_next  = clr_run_reg;
        partner_next  = partner_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_res_next    = m_res_reg;

        prog_we   = 1'b0;
        prog_wa   = lc_reg[PA-1:0];
        prog_wd   = ld_op[2:0];
        jmp_we    = 1'b0;
        jmp_wa    = lc_reg[PA-1:0];
        jmp_wd    = stk_rd;
        stk_we    = 1'b0;
        stk_wa    = sd_reg[SA-1:0];
        stk_wd    = lc_reg[PA-1:0];
        tape_we_r = 1'b0;
        tape_we_l = 1'b0;
        tape_wa   = idx_reg;
        tape_wd   = CB'(s_data_byte);

        // Drain the output register
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                tape_we_r = 1'b1;
                tape_we_l = 1'b1;
                tape_wa   = clr_reg;
                tape_wd   = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == TA'(TAPE_HALF - 1)) begin
                    clr_run_next = 1'b0;
                    state_next   = clr_run_reg ? S_START : S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EMIT;
                    res_next   = '{ST_OK, '0, pos12(pc_reg)};
                    unique case (s_cmd)
                        CMD_LOAD: begin
                            res_next.prog_pos = pos12(lc_reg);
                            if (!ld_op[3]) begin
                                res_next.status = ST_OK;
                            end else if (lc_reg >= (PA+1)'(PROG_DEPTH)) begin
                                res_next.status = ST_PROG_FULL;
                            end else if (ld_op[2:0] == OP_OPEN &&
                                         sd_reg >= (SA+1)'(NEST_DEPTH)) begin
                                res_next.status = ST_NEST_OVF;
                            end else if (ld_op[2:0] == OP_CLOSE) begin
                                if (sd_reg == '0) begin
                                    res_next.status = ST_UNM_CLOSE;
                                end else begin
                                    sd_next    = sd_reg - 1'b1;
                                    state_next = S_LD_J1;
                                end
                            end else begin
                                if (ld_op[2:0] == OP_OPEN) begin
                                    stk_we  = 1'b1;
                                    sd_next = sd_reg + 1'b1;
                                end
                                prog_we  = 1'b1;
                                lc_next  = lc_reg + 1'b1;
                                res_next.prog_pos = pos12(lc_reg + 1'b1);
                            end
                        end
                        CMD_END: begin
                            res_next.prog_pos = pos12(lc_reg);
                            if (sd_reg != '0) res_next.status = ST_UNM_OPEN;
                        end
                        CMD_RUN: begin
                            side_next     = 1'b0;
                            idx_next      = '0;
                            pc_next       = '0;
                            awaiting_next = 1'b0;
                            paused_next   = 1'b0;
                            skip_next     = 1'b0;
                            clr_next      = '0;
                            clr_run_next  = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        CMD_RESUME: begin
                            if (awaiting_reg) begin
                                res_next.status = ST_NEED_IN;
                            end else begin
                                skip_next   = paused_reg;
                                paused_next = 1'b0;
                                state_next  = S_START;
                            end
                        end
                        CMD_SUPPLY: begin
                            if (awaiting_reg) begin
                                awaiting_next = 1'b0;
                                if (s_in_eof && stop_on_eof_reg) begin
                                    res_next.status = ST_EOF_STOP;
                                end else begin
                                    if (!s_in_eof) begin
                                        tape_we_r = !side_reg;
                                        tape_we_l = side_reg;
                                    end
                                    pc_next    = pc_reg + 1'b1;
                                    skip_next  = 1'b0;
                                    state_next = S_START;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Closing bracket: link both ends of the pair
            S_LD_J1: begin
                jmp_we       = 1'b1;
                partner_next = stk_rd;
                state_next   = S_LD_J2;
            end

            S_LD_J2: begin
                jmp_we     = 1'b1;
                jmp_wa     = partner_reg;
                jmp_wd     = lc_reg[PA-1:0];
                prog_we    = 1'b1;
                prog_wd    = OP_CLOSE;
                lc_next    = lc_reg + 1'b1;
                res_next   = '{ST_OK, '0, pos12(lc_reg + 1'b1)};
                state_next = S_EMIT;
            end

            S_START: begin
                step_next = '0;
                if (sd_reg != '0) begin
                    skip_next  = 1'b0;
                    res_next   = '{ST_UNM_OPEN, '0, pos12(pc_reg)};
                    state_next = S_EMIT;
                end else begin
                    state_next = S_FETCH;
                end
            end

            // Pause checks while the memories are read
            S_FETCH: begin
                skip_next  = 1'b0;
                state_next = S_EMIT;
                res_next   = '{ST_OK, '0, pos12(pc_reg)};
                if (pc_reg >= lc_reg) begin
                    res_next.status = ST_FINISHED;
                end else if (step_reg[STEP_W-1]) begin
                    res_next.status = ST_OK;
                end else if (break_enable_reg && !skip_reg &&
                             32'(pc_reg) == 32'(break_addr_reg)) begin
                    paused_next     = 1'b1;
                    res_next.status = ST_BREAK;
                end else begin
                    state_next = S_EXEC;
                end
            end

            // Execute one instruction; increment and decrement write the cell back
            S_EXEC: begin
                step_next  = step_reg + 1'b1;
                pc_next    = pc_reg + 1'b1;
                state_next = S_FETCH;
                tape_wd    = cur_cell;
                unique case (prog_rd)
                    OP_INC: begin
                        tape_we_r = !side_reg;
                        tape_we_l = side_reg;
                        tape_wd   = cur_cell + 1'b1;
                    end
                    OP_DEC: begin
                        tape_we_r = !side_reg;
                        tape_we_l = side_reg;
                        tape_wd   = cur_cell - 1'b1;
                    end
                    OP_RIGHT, OP_LEFT: begin
                        if (to_left == side_reg) begin
                            if (idx_reg == TA'(TAPE_HALF - 1)) begin
                                pc_next    = pc_reg;
                                res_next   = '{ST_TAPE_OVF, '0, pos12(pc_reg)};
                                state_next = S_EMIT;
                            end else begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end else if (idx_reg == '0) begin
                            side_next = !side_reg;
                        end else begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                    OP_OPEN: begin
                        if (cur_cell == '0) pc_next = {1'b0, jmp_rd} + 1'b1;
                    end
                    OP_CLOSE: begin
                        if (cur_cell != '0) pc_next = {1'b0, jmp_rd} + 1'b1;
                    end
                    OP_OUT: begin
                        res_next   = '{ST_OUTPUT, cur_cell[BYTE_W-1:0],
                                       pos12(pc_reg + 1'b1)};
                        state_next = S_EMIT;
                    end
                    OP_IN: begin
                        pc_next       = pc_reg;
                        awaiting_next = 1'b1;
                        res_next      = '{ST_NEED_IN, '0, pos12(pc_reg)};
                        state_next    = S_EMIT;
                    end
                    default: ;
                endcase
            end

            // Hand the result to the output register once it is free
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            stop_on_eof_reg  <= 1'b0;
            break_enable_reg <= 1'b0;
            break_addr_reg   <= '0;
            sd_reg           <= '0;
            lc_reg           <= '0;
            pc_reg           <= '0;
            side_reg         <= 1'b0;
            idx_reg          <= '0;
            awaiting_reg     <= 1'b0;
            paused_reg       <= 1'b0;
            skip_reg         <= 1'b0;
            step_reg         <= '0;
            clr_reg          <= '0;
            clr_run_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sd_reg       <= sd_next;
            lc_reg       <= lc_next;
            pc_reg       <= pc_next;
            side_reg     <= side_next;
            idx_reg      <= idx_next;
            awaiting_reg <= awaiting_next;
            paused_reg   <= paused_next;
            skip_reg     <= skip_next;
            step_reg     <= step_next;
            clr_reg      <= clr_next;
            clr_run_reg  <= clr_run_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_STOP_ON_EOF:  stop_on_eof_reg  <= cfg_wr_data[0];
                    REG_BREAK_ENABLE: break_enable_reg <= cfg_wr_data[0];
                    REG_BREAK_ADDR:   break_addr_reg   <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
        partner_reg <= partner_next;
        res_reg     <= res_next;
        m_res_reg   <= m_res_next;
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the brainfuck machine core: directed and random request streams.
`default_nettype none

module testbench;
    import bfm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PROG_N = PROG_DEPTH_DEF;
    localparam int TAPE_N = TAPE_HALF_DEF;
    localparam int NEST_N = NEST_DEPTH_DEF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0] s_cmd = '0;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic s_in_eof = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [BYTE_W-1:0] m_out_byte;
    logic [POS_W-1:0] m_prog_pos;

    brainfuck_machine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_data_byte(s_data_byte), .s_in_eof(s_in_eof),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_byte(m_out_byte), .m_prog_pos(m_prog_pos)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Machine state as the predictor sees it
    logic [2:0]  code_mem [PROG_N];
    logic [11:0] mate_mem [PROG_N];
    logic [11:0] open_mem [NEST_N];
    logic [7:0]  tape_r [TAPE_N];
    logic [7:0]  tape_l [TAPE_N];
    int nest_depth = 0;
    int load_cnt = 0;
    int pc = 0;
    int head_idx = 0;
    bit head_left = 0;
    bit want_input = 0;
    bit at_brk = 0;
    bit eof_stop_en = 0;
    bit brk_en = 0;
    int brk_addr = 0;

    res_t result_q [$];
    int send_idle = 0;
    int recv_idle = 0;
    int errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_runs = 0;

    function automatic res_t mk(logic [3:0] st, logic [7:0] b, int pos);
        res_t r;
        r.status = st;
        r.out_byte = b;
        r.prog_pos = pos[11:0];
        return r;
    endfunction

    // Program character to opcode; returns 0 for characters that are dropped
    function automatic bit decode_char(input logic [7:0] ch, output logic [2:0] op);
        op = OP_INC;
        case (ch)
            CH_INC:   op = OP_INC;
            CH_DEC:   op = OP_DEC;
            CH_RIGHT: op = OP_RIGHT;
            CH_LEFT:  op = OP_LEFT;
            CH_OPEN:  op = OP_OPEN;
            CH_CLOSE: op = OP_CLOSE;
            CH_OUT:   op = OP_OUT;
            CH_IN:    op = OP_IN;
            default:  return 0;
        endcase
        return 1;
    endfunction

    function automatic res_t load_char(logic [7:0] ch);
        logic [2:0] op;
        logic [11:0] mate;
        if (!decode_char(ch, op)) return mk(ST_OK, 0, load_cnt);
        if (load_cnt >= PROG_N) return mk(ST_PROG_FULL, 0, load_cnt);
        if (op == OP_OPEN) begin
            if (nest_depth >= NEST_N) return mk(ST_NEST_OVF, 0, load_cnt);
            open_mem[nest_depth] = load_cnt[11:0];
            nest_depth++;
        end else if (op == OP_CLOSE) begin
            if (nest_depth == 0) return mk(ST_UNM_CLOSE, 0, load_cnt);
            nest_depth--;
            mate = open_mem[nest_depth];
            mate_mem[load_cnt] = mate;
            mate_mem[mate] = load_cnt[11:0];
        end
        code_mem[load_cnt] = op;
        load_cnt++;
        return mk(ST_OK, 0, load_cnt);
    endfunction

    // Execute from pc until a pause, fault, end of program or the step budget
    function automatic res_t execute(bit skip_brk);
        int n;
        logic [7:0] c;
        if (nest_depth != 0) return mk(ST_UNM_OPEN, 0, pc);
        n = 0;
        forever begin
            if (pc >= load_cnt) return mk(ST_FINISHED, 0, pc);
            if (n >= STEP_BUDGET) return mk(ST_OK, 0, pc);
            if (brk_en && pc == brk_addr && !(skip_brk && n == 0)) begin
                at_brk = 1;
                return mk(ST_BREAK, 0, pc);
            end
            c = head_left ? tape_l[head_idx] : tape_r[head_idx];
            case (code_mem[pc])
                OP_INC, OP_DEC: begin
                    c = (code_mem[pc] == OP_INC) ? c + 8'd1 : c - 8'd1;
                    if (head_left) tape_l[head_idx] = c;
                    else tape_r[head_idx] = c;
                end
                OP_RIGHT, OP_LEFT: begin
                    // moving away from index 0 grows the index, towards it shrinks it and crosses sides at 0
                    if ((code_mem[pc] == OP_LEFT) == head_left) begin
                        if (head_idx + 1 >= TAPE_N) return mk(ST_TAPE_OVF, 0, pc);
                        head_idx++;
                    end else if (head_idx == 0) begin
                        head_left = !head_left;
                    end else begin
                        head_idx--;
                    end
                end
                OP_OPEN: if (c == 0) pc = int'(mate_mem[pc]);
                OP_CLOSE: if (c != 0) pc = int'(mate_mem[pc]);
                OP_OUT: begin
                    pc++;
                    return mk(ST_OUTPUT, c, pc);
                end
                default: begin
                    want_input = 1;
                    return mk(ST_NEED_IN, 0, pc);
                end
            endcase
            pc++;
            n++;
        end
    endfunction

    function automatic res_t predict_result(logic [2:0] cmd, logic [7:0] data, bit eof);
        bit skip;
        case (cmd)
            CMD_LOAD: return load_char(data);
            CMD_END: return mk(nest_depth != 0 ? ST_UNM_OPEN : ST_OK, 0, load_cnt);
            CMD_RUN: begin
                for (int i = 0; i < TAPE_N; i++) begin
                    tape_r[i] = 8'd0;
                    tape_l[i] = 8'd0;
                end
                head_left = 0;
                head_idx = 0;
                pc = 0;
                want_input = 0;
                at_brk = 0;
                return execute(0);
            end
            CMD_RESUME: begin
                if (want_input) return mk(ST_NEED_IN, 0, pc);
                skip = at_brk;
                at_brk = 0;
                return execute(skip);
            end
            CMD_SUPPLY: begin
                if (!want_input) return mk(ST_OK, 0, pc);
                want_input = 0;
                if (eof) begin
                    if (eof_stop_en) return mk(ST_EOF_STOP, 0, pc);
                end else if (head_left) begin
                    tape_l[head_idx] = data;
                end else begin
                    tape_r[head_idx] = data;
                end
                pc++;
                return execute(0);
            end
            default: return mk(ST_OK, 0, pc);
        endcase
    endfunction

    // Result checker
    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (result_q.size() == 0) begin
                $error("unexpected result: status %0d byte %0d pos %0d",
                       m_status, m_out_byte, m_prog_pos);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    errors++;
                end
                if (m_out_byte !== e.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", e.out_byte, m_out_byte);
                    errors++;
                end
                if (m_prog_pos !== e.prog_pos) begin
                    $error("prog_pos: expected %0d, got %0d", e.prog_pos, m_prog_pos);
                    errors++;
                end
            end
        end
    end

    // Result-side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Send one request; entered and left at a falling edge, valid left high
    task automatic send_req(input logic [2:0] cmd, input logic [7:0] data, input bit eof,
                            output res_t r);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_cmd = cmd;
        s_data_byte = data;
        s_in_eof = eof;
        do @(posedge aclk); while (!s_ready);
        r = predict_result(cmd, data, eof);
        result_q.insert(result_q.size(), r);
        n_requests++;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drain();
        s_valid = 1'b0;
        while (result_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        s_valid = 1'b0;
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_STOP_ON_EOF:  eof_stop_en = value[0];
            REG_BREAK_ENABLE: brk_en = value[0];
            default:          brk_addr = value & 12'hFFF;
        endcase
    endtask

    task automatic set_config(input bit eof_stop, input bit brk, input int addr);
        wait_drain();
        write_reg(REG_STOP_ON_EOF, int'(eof_stop));
        write_reg(REG_BREAK_ENABLE, int'(brk));
        write_reg(REG_BREAK_ADDR, addr);
    endtask

    task automatic load_text(input string s);
        res_t r;
        foreach (s[i]) send_req(CMD_LOAD, s[i], 1'($urandom_range(1)), r);
    endtask

    // Run from the start and keep the machine going until it stops for good or cap follow-up requests are sent
    task automatic run_program(input int cap);
        res_t r;
        send_req(CMD_RUN, 8'($urandom), 1'($urandom_range(1)), r);
        n_runs++;
        for (int k = 0; k < cap; k++) begin
            if (r.status == ST_NEED_IN) begin
                if ($urandom_range(19) == 0) send_req(CMD_RESUME, 8'($urandom), 0, r);
                else send_req(CMD_SUPPLY, 8'($urandom), $urandom_range(9) == 0, r);
            end else if (r.status inside {ST_OK, ST_OUTPUT, ST_BREAK, ST_EOF_STOP}) begin
                // occasional stray request that the machine just answers with ok
                if ($urandom_range(19) == 0)
                    send_req($urandom_range(4) == 0 ? CMD_SUPPLY : 3'($urandom_range(7, 5)),
                             8'($urandom), 1'($urandom_range(1)), r);
                else
                    send_req(CMD_RESUME, 8'($urandom), 1'($urandom_range(1)), r);
            end else begin
                break;
            end
        end
    endtask

    // Append a short terminating program fragment, sometimes a broken one
    task automatic load_fragment();
        res_t r;
        logic [7:0] ch;
        logic [2:0] op;
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            send_req(CMD_LOAD, CH_CLOSE, 0, r);
        end else if (sel == 1) begin
            send_req(CMD_LOAD, CH_OPEN, 0, r);
            send_req(CMD_END, 8'($urandom), 1'($urandom_range(1)), r);
            send_req(CMD_RUN, 8'($urandom), 0, r);
            send_req(CMD_SUPPLY, 8'($urandom), 1'($urandom_range(1)), r);
            load_text("-]");
        end
        repeat ($urandom_range(3, 12)) begin
            case ($urandom_range(9))
                0: load_text("+");
                1: load_text("-");
                2: load_text(">");
                3: load_text("<");
                4: load_text(".");
                5: load_text(",");
                6: load_text("[-]");
                7: load_text("[->+<]");
                8: load_text("[+]");
                default: begin
                    do ch = 8'($urandom_range(255)); while (decode_char(ch, op));
                    send_req(CMD_LOAD, ch, 1'($urandom_range(1)), r);
                end
            endcase
        end
        send_req(CMD_END, 8'($urandom), 1'($urandom_range(1)), r);
    endtask

    // Corner cases of loading, pausing, input and breakpoints
    task automatic test_directed();
        res_t r;
        send_req(CMD_END, 8'h00, 0, r);
        send_req(CMD_RESUME, 8'h00, 0, r);
        send_req(CMD_SUPPLY, 8'hFF, 1, r);
        send_req(3'd5, 8'h00, 0, r);
        send_req(3'd6, 8'hFF, 1, r);
        send_req(3'd7, 8'h55, 0, r);
        send_req(CMD_LOAD, CH_CLOSE, 0, r);
        send_req(CMD_LOAD, 8'h00, 0, r);
        send_req(CMD_LOAD, 8'hFF, 1, r);
        load_text("[");
        send_req(CMD_END, 8'h00, 0, r);
        send_req(CMD_RUN, 8'h00, 0, r);
        send_req(CMD_RESUME, 8'h00, 0, r);
        load_text("]-.,.");
        send_req(CMD_END, 8'h00, 0, r);
        run_program(12);
        // end of input with stop enabled, then a breakpoint stepped over on resume
        set_config(1, 0, 0);
        send_req(CMD_RUN, 8'h00, 0, r);
        send_req(CMD_RESUME, 8'h00, 0, r);
        send_req(CMD_SUPPLY, 8'h00, 1, r);
        send_req(CMD_RESUME, 8'h00, 0, r);
        send_req(CMD_SUPPLY, 8'hFF, 0, r);
        send_req(CMD_RESUME, 8'h00, 0, r);
        set_config(0, 1, 2);
        run_program(10);
        set_config(0, 1, 4095);
        run_program(10);
        wait_drain();
    endtask

    task automatic test_random(input int target, input bit eof_stop);
        int goal;
        goal = n_requests + target;
        while (n_requests < goal) begin
            case ($urandom_range(3))
                0: set_config(eof_stop, 1, 0);
                1: set_config(eof_stop, 1, $urandom_range(load_cnt));
                default: set_config(eof_stop, 0, $urandom_range(4095));
            endcase
            load_fragment();
            run_program(60);
        end
        wait_drain();
    endtask

    // Full nesting stack, with the overflowing open bracket refused
    task automatic test_nesting();
        res_t r;
        set_config(0, 0, 0);
        load_text("[-]");
        repeat (NEST_N + 1) send_req(CMD_LOAD, CH_OPEN, 0, r);
        send_req(CMD_END, 8'h00, 0, r);
        repeat (NEST_N) send_req(CMD_LOAD, CH_CLOSE, 0, r);
        send_req(CMD_END, 8'h00, 0, r);
        wait_drain();
    endtask

    // Long nested loop across the step budget, then a walk off the tape end
    task automatic test_budget_and_tape();
        load_text("-[>-[-]<-]+[>+]");
        run_program(400);
        wait_drain();
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        send_idle = 32;
        recv_idle = 87;
        test_directed();
        test_random(160, 0);
        send_idle = 87;
        recv_idle = 32;
        test_random(160, 1);
        send_idle = 0;
        recv_idle = 0;
        test_random(160, 0);
        test_nesting();
        test_budget_and_tape();
        repeat (20) @(posedge aclk);
        $display("Covered %0d requests, %0d results checked, %0d program runs.",
                 n_requests, n_results, n_runs);
        $display("Program length at end %0d, mismatches %0d.", load_cnt, errors);
        if (errors == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd8_000_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
